/* src/assert_macros.svh */
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SVCP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("svcp assertion violated");

`define SVCP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("svcp assertion violated");

`else

`define SVCP_ASSERT(lbl, clk, rstn, prop)

`define SVCP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* src/svcp_pkg.sv */
package svcp_pkg;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_T      = 8'h54;
    localparam logic [7:0] CHAR_BANG   = 8'h21;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;

    localparam logic [7:0] SERVO_COUNT_RESET = 8'd32;

    typedef enum logic [4:0] {
        MODE_OUTSIDE = 5'b00001,
        MODE_GROUP   = 5'b00010,
        MODE_INDEX   = 5'b00100,
        MODE_POS     = 5'b01000,
        MODE_TIME    = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_req_t;

    typedef struct packed {
        logic [7:0] servo_count;
    } cfg_req_t;

    typedef struct packed {
        logic [7:0]         servo_index;
        logic signed [31:0] target_position;
        logic [15:0]        move_time;
    } cmd_req_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } byte_slot_t;

    typedef struct packed {
        logic     valid;
        cmd_req_t cmd;
    } parse_res_t;

    // acc * 10 + digit, wrapping at 32 bits
    function automatic logic [31:0] next_digit(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] sum;
        sum = (acc << 3) + (acc << 1) + {24'd0, b} - {24'd0, CHAR_ZERO};
        return sum;
    endfunction

endpackage

/* src/svcp_stream_if.sv */
interface svcp_stream_if #(
    parameter type payload_t = svcp_pkg::rx_req_t
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

/* src/svcp_in_reg.sv */
module svcp_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [7:0]          req_byte,
    input  logic                advance,
    output logic                req_ready,
    output svcp_pkg::byte_slot_t slot
);
    import svcp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    assign req_ready  = !valid_reg || advance;
    assign load       = req_valid && req_ready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= req_byte;
        end
    end

    // present the request only when it is consumed this cycle
    assign slot.valid   = valid_reg && advance;
    assign slot.rx_byte = byte_reg;
endmodule

/* src/svcp_parse_core.sv */
module svcp_parse_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  svcp_pkg::byte_slot_t slot,
    input  logic [7:0]           servo_count,
    output svcp_pkg::parse_res_t res
);
    import svcp_pkg::*;

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [15:0] index_reg;
    logic [15:0] index_next;
    logic [31:0] pos_reg;
    logic [31:0] pos_next;
    logic [15:0] time_reg;
    logic [15:0] time_next;
    logic [31:0] index_step;
    logic [31:0] pos_step;
    logic [31:0] time_step;

    assign index_step = next_digit({16'd0, index_reg}, slot.rx_byte);
    assign pos_step   = next_digit(pos_reg, slot.rx_byte);
    assign time_step  = next_digit({16'd0, time_reg}, slot.rx_byte);

    always_comb
    begin
        mode_next                   = mode_reg;
        index_next                  = index_reg;
        pos_next                    = pos_reg;
        time_next                   = time_reg;
        res.valid                   = 1'b0;
        res.cmd.servo_index         = index_reg[7:0];
        res.cmd.target_position     = pos_reg;
        res.cmd.move_time           = time_reg;
        if (slot.valid)
        begin
            if (slot.rx_byte == CHAR_NUL)
            begin
                mode_next  = MODE_OUTSIDE;
                index_next = 16'd0;
                pos_next   = 32'd0;
                time_next  = 16'd0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_GROUP:
                    begin
                        if (slot.rx_byte == CHAR_HASH)
                        begin
                            mode_next  = MODE_INDEX;
                            index_next = 16'd0;
                        end
                        else if (slot.rx_byte == CHAR_RBRACE || slot.rx_byte == CHAR_GT)
                        begin
                            mode_next = MODE_OUTSIDE;
                        end
                    end
                    MODE_INDEX:
                    begin
                        if (slot.rx_byte == CHAR_P)
                        begin
                            mode_next = MODE_POS;
                            pos_next  = 32'd0;
                        end
                        else
                        begin
                            index_next = index_step[15:0];
                        end
                    end
                    MODE_POS:
                    begin
                        if (slot.rx_byte == CHAR_T)
                        begin
                            mode_next = MODE_TIME;
                            time_next = 16'd0;
                        end
                        else
                        begin
                            pos_next = pos_step;
                        end
                    end
                    MODE_TIME:
                    begin
                        if (slot.rx_byte == CHAR_BANG)
                        begin
                            mode_next = MODE_GROUP;
                            res.valid = (index_reg < {8'd0, servo_count});
                        end
                        else
                        begin
                            time_next = time_step[15:0];
                        end
                    end
                    default:
                    begin
                        if (slot.rx_byte == CHAR_LBRACE || slot.rx_byte == CHAR_LT)
                        begin
                            mode_next = MODE_GROUP;
                        end
                        else
                        begin
                            mode_next = MODE_OUTSIDE;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_OUTSIDE;
            index_reg <= 16'd0;
            pos_reg   <= 32'd0;
            time_reg  <= 16'd0;
        end
        else
        begin
            mode_reg  <= mode_next;
            index_reg <= index_next;
            pos_reg   <= pos_next;
            time_reg  <= time_next;
        end
    end
endmodule

/* src/svcp_out_reg.sv */
module svcp_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  svcp_pkg::parse_res_t res,
    input  logic                 out_ready,
    output logic                 advance,
    output logic                 out_valid,
    output svcp_pkg::cmd_req_t   out_cmd
);
    import svcp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    cmd_req_t cmd_reg;

    assign advance    = !valid_reg || out_ready;
    assign valid_next = advance ? res.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the result until taken
    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            cmd_reg <= res.cmd;
        end
    end

    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;
endmodule

/* src/servo_command_parser_unit.sv */
// Servo command parser.
// rx  : sink of text bytes, one request per character; a zero byte ends the message.
// cmd : source of decoded commands (servo_index, target_position, move_time),
//       one request per '#..P..T..!' inside a '{'/'<' group with index below servo_count.
// cfg : write of servo_count; always ready; write only while the block is idle.
// Result path: a '!' accepted on rx is held in the input register, then decoded into the
//              output register, which drives cmd.valid.
// Throughput: one byte per cycle while cmd is not stalled; the decode between the input
//             register and the output register is combinational.
// Reset: group closed, all field accumulators zero, servo_count back to 32.
// Stall: while cmd is held, the result stays put, one more byte is buffered in the
//        input register, then rx.ready drops until cmd.ready returns.
`include "assert_macros.svh"

module servo_command_parser_unit (
    input logic          clk,
    input logic          rst_n,
    svcp_stream_if.sink   cfg,
    svcp_stream_if.sink   rx,
    svcp_stream_if.source cmd
);
    import svcp_pkg::*;

    logic       [7:0] servo_count_reg;
    logic       [7:0] servo_count_next;
    logic             advance;
    byte_slot_t       slot;
    parse_res_t       res;
    cmd_req_t         out_cmd;

    assign cfg.ready        = 1'b1;
    assign servo_count_next = (cfg.valid && cfg.ready) ? cfg.payload.servo_count
                                                       : servo_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_count_reg <= SERVO_COUNT_RESET;
        end
        else
        begin
            servo_count_reg <= servo_count_next;
        end
    end

    svcp_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (rx.valid),
        .req_byte  (rx.payload.rx_byte),
        .advance   (advance),
        .req_ready (rx.ready),
        .slot      (slot)
    );

    svcp_parse_core u_parse_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .slot        (slot),
        .servo_count (servo_count_reg),
        .res         (res)
    );

    svcp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .out_ready (cmd.ready),
        .advance   (advance),
        .out_valid (cmd.valid),
        .out_cmd   (out_cmd)
    );

    assign cmd.payload = out_cmd;

    `SVCP_ASSERT(a_res_on_bang, clk, rst_n, res.valid |-> (slot.valid && slot.rx_byte == CHAR_BANG))
    `SVCP_ASSERT(a_res_index_ok, clk, rst_n, res.valid |-> (res.cmd.servo_index < servo_count_reg))
    `SVCP_ASSERT(a_res_needs_room, clk, rst_n, res.valid |-> advance)
    `SVCP_ASSERT(a_stall_blocks_rx, clk, rst_n, (slot.valid == 1'b0 && !advance && rx.ready) |-> !u_in_reg.valid_reg)
endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import svcp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 6;

    logic clk;
    logic rst_n;

    svcp_stream_if #(.payload_t(cfg_req_t)) cfg_if ();
    svcp_stream_if #(.payload_t(rx_req_t))  rx_if ();
    svcp_stream_if #(.payload_t(cmd_req_t)) cmd_if ();

    servo_command_parser_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .rx    (rx_if),
        .cmd   (cmd_if)
    );

    logic [7:0] text_q[$];
    cmd_req_t   cmd_exp[$];

    mode_t       cmd_mode;
    logic [15:0] idx_acc;
    logic [31:0] pos_acc;
    logic [15:0] time_acc;
    logic [7:0]  servo_limit;

    bit rx_taken;
    bit cfg_taken;
    bit quiet;
    bit failed;
    int rx_gap;
    int cmd_gap;
    int cycles;
    int phase_count;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic bit parse_byte(input logic [7:0] b, output cmd_req_t res);
        bit hit;
        hit = 1'b0;
        res = '0;
        if (b == CHAR_NUL)
        begin
            cmd_mode = MODE_OUTSIDE;
            idx_acc  = '0;
            pos_acc  = '0;
            time_acc = '0;
            return 1'b0;
        end
        case (cmd_mode)
            MODE_GROUP:
            begin
                if (b == CHAR_HASH)
                begin
                    cmd_mode = MODE_INDEX;
                    idx_acc  = '0;
                end
                else if (b == CHAR_RBRACE || b == CHAR_GT)
                begin
                    cmd_mode = MODE_OUTSIDE;
                end
            end
            MODE_INDEX:
            begin
                if (b == CHAR_P)
                begin
                    cmd_mode = MODE_POS;
                    pos_acc  = '0;
                end
                else
                begin
                    idx_acc = idx_acc * 16'd10 + {8'd0, b} - {8'd0, CHAR_ZERO};
                end
            end
            MODE_POS:
            begin
                if (b == CHAR_T)
                begin
                    cmd_mode = MODE_TIME;
                    time_acc = '0;
                end
                else
                begin
                    pos_acc = pos_acc * 32'd10 + {24'd0, b} - {24'd0, CHAR_ZERO};
                end
            end
            MODE_TIME:
            begin
                if (b == CHAR_BANG)
                begin
                    cmd_mode = MODE_GROUP;
                    if (idx_acc < {8'd0, servo_limit})
                    begin
                        res.servo_index     = idx_acc[7:0];
                        res.target_position = pos_acc;
                        res.move_time       = time_acc;
                        hit = 1'b1;
                    end
                end
                else
                begin
                    time_acc = time_acc * 16'd10 + {8'd0, b} - {8'd0, CHAR_ZERO};
                end
            end
            default:
            begin
                cmd_mode = MODE_OUTSIDE;
                if (b == CHAR_LBRACE || b == CHAR_LT)
                    cmd_mode = MODE_GROUP;
            end
        endcase
        return hit;
    endfunction

    always @(posedge clk)
    begin : monitor
        cmd_req_t want;
        cmd_req_t got;
        rx_taken  = 1'b0;
        cfg_taken = 1'b0;
        if (rst_n)
        begin
            if (cmd_if.valid && cmd_if.ready)
            begin
                got = cmd_if.payload;
                if (cmd_exp.size() == 0)
                begin
                    $display("%0t unexpected command: index %0d position %0d time %0d",
                             $time, got.servo_index, got.target_position, got.move_time);
                    failed = 1'b1;
                end
                else
                begin
                    want = cmd_exp.pop_front();
                    if (got.servo_index !== want.servo_index)
                    begin
                        $display("%0t servo_index: expected %0d actual %0d",
                                 $time, want.servo_index, got.servo_index);
                        failed = 1'b1;
                    end
                    if (got.target_position !== want.target_position)
                    begin
                        $display("%0t target_position: expected %0d actual %0d",
                                 $time, want.target_position, got.target_position);
                        failed = 1'b1;
                    end
                    if (got.move_time !== want.move_time)
                    begin
                        $display("%0t move_time: expected %0d actual %0d",
                                 $time, want.move_time, got.move_time);
                        failed = 1'b1;
                    end
                end
            end
            if (rx_if.valid && rx_if.ready)
            begin
                rx_taken = 1'b1;
                if (parse_byte(rx_if.payload.rx_byte, want))
                    cmd_exp.push_back(want);
            end
            if (cfg_if.valid && cfg_if.ready)
            begin
                cfg_taken   = 1'b1;
                servo_limit = cfg_if.payload.servo_count;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!rx_if.valid || rx_taken))
        begin
            if (rx_gap > 0)
            begin
                rx_gap--;
                rx_if.valid <= 1'b0;
            end
            else if (text_q.size() == 0)
            begin
                rx_if.valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                rx_gap = $urandom_range(0, 9);
                rx_if.valid <= 1'b0;
            end
            else
            begin
                rx_if.payload <= text_q.pop_front();
                rx_if.valid   <= 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin
        if (cmd_gap > 0)
        begin
            cmd_gap--;
            cmd_if.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            cmd_gap = $urandom_range(0, 9);
            cmd_if.ready <= 1'b0;
        end
        else
        begin
            cmd_if.ready <= 1'b1;
        end
    end

    task automatic push_text(input string s);
        foreach (s[i])
            text_q.push_back(s[i]);
    endtask

    task automatic push_number(input longint unsigned v);
        logic [7:0]      digs[$];
        longint unsigned t;
        t = v;
        do
        begin
            digs.push_front(8'(t % 10) + CHAR_ZERO);
            t = t / 10;
        end
        while (t != 0);
        foreach (digs[i])
            text_q.push_back(digs[i]);
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 11) == 0)
            text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic push_command(input int count);
        int r;
        text_q.push_back(CHAR_HASH);
        r = $urandom_range(0, 9);
        if (r < 7)
            push_number(count == 0 ? 0 : $urandom_range(0, count - 1));
        else if (r == 7)
            push_number(count + $urandom_range(0, 5));
        else if (r == 8)
            push_number(65536 * $urandom_range(1, 3) + $urandom_range(0, count));
        else
            push_number($urandom_range(0, 99999));
        maybe_noise();
        text_q.push_back(CHAR_P);
        r = $urandom_range(0, 5);
        if (r < 2)
            push_number($urandom());
        else if (r == 2)
            push_number(64'd2147483647);
        else if (r == 3)
            push_number(64'd4294967295 + $urandom_range(1, 1000000));
        else
            push_number($urandom_range(0, 9999));
        maybe_noise();
        text_q.push_back(CHAR_T);
        r = $urandom_range(0, 4);
        if (r == 0)
            push_number(65535);
        else if (r == 1)
            push_number($urandom_range(0, 999999));
        else
            push_number($urandom_range(0, 65535));
        maybe_noise();
        text_q.push_back($urandom_range(0, 14) == 0 ? CHAR_NUL : CHAR_BANG);
    endtask

    task automatic fill_phase(input int count, input int nbytes);
        int start;
        int n;
        int r;
        start = text_q.size();
        while (text_q.size() - start < nbytes)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    text_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                text_q.push_back($urandom_range(0, 1) ? CHAR_LBRACE : CHAR_LT);
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    push_command(count);
                    maybe_noise();
                end
                r = $urandom_range(0, 9);
                if (r < 4)
                    text_q.push_back(CHAR_RBRACE);
                else if (r < 8)
                    text_q.push_back(CHAR_GT);
                else if (r == 8)
                    text_q.push_back(CHAR_NUL);
            end
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (text_q.size() != 0 || rx_if.valid || cmd_exp.size() != 0);
        repeat (SETTLE_TICKS)
            @(posedge clk);
    endtask

    task automatic write_count(input logic [7:0] v);
        @(negedge clk);
        cfg_if.payload <= v;
        cfg_if.valid   <= 1'b1;
        do
        begin
            @(posedge clk);
            #1;
        end
        while (!cfg_taken);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial
    begin
        int counts[7];
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.payload  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        cmd_if.ready   = 1'b0;
        cmd_mode       = MODE_OUTSIDE;
        idx_acc        = '0;
        pos_acc        = '0;
        time_acc       = '0;
        servo_limit    = SERVO_COUNT_RESET;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_text("{#5P7T9!#40P1T2!>");
        push_text("<#3P4T5");
        text_q.push_back(CHAR_NUL);
        wait_drained();

        counts = '{255, 1, 0, 2, 255, 100, 32};
        counts[3] = $urandom_range(2, 254);
        counts[5] = $urandom_range(1, 254);
        foreach (counts[i])
        begin
            phase_count = counts[i];
            if (i == 6)
                quiet = 1'b1;
            write_count(8'(phase_count));
            fill_phase(phase_count, phase_count == 0 ? 40 : 145);
            wait_drained();
        end

        if (failed)
            $display("status: fail");
        else
            $display("status: pass");
        $finish;
    end
endmodule

/* sim.f */
+incdir+src
src/svcp_pkg.sv
src/svcp_stream_if.sv
src/svcp_in_reg.sv
src/svcp_parse_core.sv
src/svcp_out_reg.sv
src/servo_command_parser_unit.sv
bench/testbench.sv
